### rtl/wps_pkg.sv
// Shared types and constants for the WS2812 pixel serializer.
// No dependencies; every other file of the block imports this package.
package wps_pkg;

  localparam int TIME_W     = 16;
  localparam int PIXEL_BITS = 24;
  localparam int SEG_W      = 6;
  localparam int CFG_IDX_W  = 3;

  // Segment numbers: 0..47 carry the bits, 48 is the latch after a frame.
  localparam logic [SEG_W-1:0] LAST_BIT_SEG = 6'd47;
  localparam logic [SEG_W-1:0] LATCH_SEG    = 6'd48;

  localparam logic [TIME_W-1:0] ZERO_HIGH_RST = 16'd60;
  localparam logic [TIME_W-1:0] ZERO_LOW_RST  = 16'd128;
  localparam logic [TIME_W-1:0] ONE_HIGH_RST  = 16'd120;
  localparam logic [TIME_W-1:0] ONE_LOW_RST   = 16'd68;
  localparam logic [TIME_W-1:0] LATCH_LOW_RST = 16'd45000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_HIGH = 3'd0,
    REG_ZERO_LOW  = 3'd1,
    REG_ONE_HIGH  = 3'd2,
    REG_ONE_LOW   = 3'd3,
    REG_LATCH_LOW = 3'd4
  } cfg_reg_t;

  // One pixel as it goes out on the line: green, red, blue, MSB first.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] word;
    logic                  eof;
  } pixel_t;

  typedef struct packed {
    logic [TIME_W-1:0] zero_high;
    logic [TIME_W-1:0] zero_low;
    logic [TIME_W-1:0] one_high;
    logic [TIME_W-1:0] one_low;
    logic [TIME_W-1:0] latch_low;
  } timing_t;

endpackage

### rtl/wps_front.sv
// Front end: accepts pixel transactions and packs them into line order.
// Depends on wps_pkg.
module wps_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  input  logic            end_of_frame,
  output logic            push_valid,
  input  logic            push_ready,
  output wps_pkg::pixel_t push_data
);
  import wps_pkg::*;

  logic   held;
  pixel_t held_data;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_data  = held_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data.word <= {green, red, blue};
      held_data.eof  <= end_of_frame;
    end
  end

endmodule

### rtl/wps_fifo.sv
// Two-entry pixel queue between the front end and the segment generator.
// Depends on wps_pkg.
module wps_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  wps_pkg::pixel_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output wps_pkg::pixel_t pop_data
);
  import wps_pkg::*;

  pixel_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

### rtl/wps_back.sv
// Back end: walks one pixel through its segments into the output register.
// Depends on wps_pkg.
module wps_back (
  input  logic                      clk,
  input  logic                      rst,
  input  wps_pkg::timing_t          timing,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  wps_pkg::pixel_t           pop_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      line_level,
  output logic [wps_pkg::TIME_W-1:0] hold_cycles,
  output logic                      last_segment
);
  import wps_pkg::*;

  logic                  active;
  logic [PIXEL_BITS-1:0] shift_word;
  logic                  eof;
  logic [SEG_W-1:0]      seg;

  logic                  issue;
  logic                  is_final;
  logic                  is_latch;
  logic                  cur_bit;
  logic                  seg_level;
  logic [TIME_W-1:0]     seg_hold;

  assign issue     = active && (!out_valid || out_ready);
  assign is_final  = (seg == (eof ? LATCH_SEG : LAST_BIT_SEG));
  assign pop_ready = !active || (issue && is_final);
  assign is_latch  = (seg == LATCH_SEG);
  assign cur_bit   = shift_word[PIXEL_BITS-1];
  assign seg_level = !seg[0] && !is_latch;

  always_comb begin
    priority if (is_latch) begin
      seg_hold = timing.latch_low;
    end else if (seg[0]) begin
      seg_hold = cur_bit ? timing.one_low : timing.zero_low;
    end else begin
      seg_hold = cur_bit ? timing.one_high : timing.zero_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      seg    <= '0;
    end else begin
      if (pop_ready) active <= pop_valid;
      if (pop_ready && pop_valid) begin
        seg        <= '0;
        shift_word <= pop_data.word;
        eof        <= pop_data.eof;
      end else if (issue) begin
        seg <= seg + 6'd1;
        // advance to the next bit after its low half
        if (seg[0]) shift_word <= {shift_word[PIXEL_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      line_level   <= seg_level;
      hold_cycles  <= seg_hold;
      last_segment <= is_final;
    end
  end

endmodule

### rtl/ws2812_pixel_serializer.sv
// Top level of the WS2812 pixel serializer: timing registers and the
// front end, pixel queue and segment generator. Depends on wps_pkg,
// wps_front, wps_fifo and wps_back.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_ready   red, green, blue, end_of_frame
//   output    out        out_valid / out_ready line_level, hold_cycles, last_segment
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each pixel yields 48 segments (49 with end_of_frame); while the output is
// not stalled, the segment generator loads one segment per cycle into the
// output register, and a queued pixel starts in the cycle after the previous pixel's last segment.
// Reset is synchronous: it empties the queue and loads the timing defaults.
// A stalled output holds the current segment; the queue and the front
// register keep taking pixels until two are waiting and one is held.
module ws2812_pixel_serializer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  logic                        end_of_frame,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        line_level,
  output logic [wps_pkg::TIME_W-1:0]  hold_cycles,
  output logic                        last_segment,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wps_pkg::TIME_W-1:0]  cfg_data
);
  import wps_pkg::*;

  timing_t           timing;
  logic [TIME_W-1:0] cfg_value;

  logic   push_valid;
  logic   push_ready;
  pixel_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  pixel_t pop_data;

  // Configuration writes are always accepted at once.
  assign cfg_ready = 1'b1;

  // A zero time would give an empty segment: store it as 1 instead.
  assign cfg_value = (cfg_data == '0) ? 16'd1 : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.zero_high <= ZERO_HIGH_RST;
      timing.zero_low  <= ZERO_LOW_RST;
      timing.one_high  <= ONE_HIGH_RST;
      timing.one_low   <= ONE_LOW_RST;
      timing.latch_low <= LATCH_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to indexes past the register list
      unique case (cfg_index)
        REG_ZERO_HIGH: timing.zero_high <= cfg_value;
        REG_ZERO_LOW:  timing.zero_low  <= cfg_value;
        REG_ONE_HIGH:  timing.one_high  <= cfg_value;
        REG_ONE_LOW:   timing.one_low   <= cfg_value;
        REG_LATCH_LOW: timing.latch_low <= cfg_value;
        default: ;
      endcase
    end
  end

  // Hold an accepted pixel in line order until the queue takes it.
  wps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_frame (end_of_frame),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  wps_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Advance through the segments of one pixel, one per free output slot.
  wps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .timing       (timing),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_level   (line_level),
    .hold_cycles  (hold_cycles),
    .last_segment (last_segment)
  );

  a_hold_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hold_cycles != '0))
    else $error("segment with zero hold time");

  a_high_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_level) |-> !last_segment)
    else $error("high segment flagged as last of pixel");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && !pop_ready && push_valid && push_ready) |=> pop_valid)
    else $error("queue lost its pending pixel");

endmodule
